/* rtl/uce_pkg.sv */
// Package with the shared types, constants and the encoding function of the character encoder.
package uce_pkg;

  // Encoding mode codes held in the configuration register.
  typedef enum logic [1:0] {
    ModeLatin1  = 2'd0,
    ModeUtf8    = 2'd1,
    ModeUtf16Le = 2'd2,
    ModeUtf16Be = 2'd3
  } enc_mode_e;

  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [7:0]  Latin1Replacement = 8'h3F;

  // One classified character: its bytes in emission order and the index of the last one.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_item_t;

  // Classification result of the front end.
  typedef struct packed {
    logic      keep;
    enc_item_t item;
  } enc_result_t;

  // Turns one code point into its byte run for the given mode.
  function automatic enc_result_t encode(logic [31:0] cp, enc_mode_e mode);
    enc_result_t r;
    r.keep          = 1'b1;
    r.item.bytes    = '0;
    r.item.last_idx = 2'd0;
    case (mode)
      ModeLatin1: begin
        r.item.bytes[0] = (cp[31:8] == '0) ? cp[7:0] : Latin1Replacement;
      end
      ModeUtf8: begin
        if (cp[31:7] == '0) begin
          r.item.bytes[0] = cp[7:0];
        end else if (cp[31:11] == '0) begin
          r.item.bytes[0]   = {3'b110, cp[10:6]};
          r.item.bytes[1]   = {2'b10, cp[5:0]};
          r.item.last_idx   = 2'd1;
        end else if (cp[31:16] == '0) begin
          r.item.bytes[0]   = {4'b1110, cp[15:12]};
          r.item.bytes[1]   = {2'b10, cp[11:6]};
          r.item.bytes[2]   = {2'b10, cp[5:0]};
          r.item.last_idx   = 2'd2;
        end else if (cp[31:21] == '0) begin
          r.item.bytes[0]   = {5'b11110, cp[20:18]};
          r.item.bytes[1]   = {2'b10, cp[17:12]};
          r.item.bytes[2]   = {2'b10, cp[11:6]};
          r.item.bytes[3]   = {2'b10, cp[5:0]};
          r.item.last_idx   = 2'd3;
        end else begin
          r.keep = 1'b0;
        end
      end
      ModeUtf16Le: begin
        r.item.bytes[0] = cp[7:0];
        r.item.bytes[1] = cp[15:8];
        r.item.last_idx = 2'd1;
      end
      ModeUtf16Be: begin
        r.item.bytes[0] = cp[15:8];
        r.item.bytes[1] = cp[7:0];
        r.item.last_idx = 2'd1;
      end
      default: begin
        r.keep = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/uce_front.sv */
// Front end: holds the mode register, accepts code points and classifies them into byte runs.
module uce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              push_i,
  input  logic [31:0]       code_point_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output uce_pkg::enc_item_t q_item_o
);
  import uce_pkg::*;

  enc_mode_e   mode_q, mode_d;
  enc_result_t res;

  // Mode register, written whenever the configuration port strobes.
  always_comb begin
    mode_d = mode_q;
    if (cfg_we_i) begin
      mode_d = enc_mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLatin1;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Classify the incoming code point; characters that encode to nothing are dropped here.
  assign res      = encode(code_point_i, mode_q);
  assign q_item_o = res.item;
  assign q_push_o = push_i && !q_full_i && res.keep;

endmodule

/* rtl/uce_queue.sv */
// Short queue of classified characters between the front end and the back end.
module uce_queue #(
  parameter int unsigned QueueDepth = uce_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  uce_pkg::enc_item_t wdata_i,
  input  logic               pop_i,
  output uce_pkg::enc_item_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import uce_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  enc_item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/uce_back.sv */
// Back end: sends each queued character's bytes, one per cycle while popped, to the output register.
module uce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  uce_pkg::enc_item_t q_item_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               char_done_o
);
  import uce_pkg::*;

  enc_item_t  cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       done_q, done_d;
  logic       out_ld, is_last;

  assign is_last = (idx_q == cur_q.last_idx);
  assign out_ld  = cur_valid_q && (!out_valid_q || pop_i);
  assign q_pop_o = !q_empty_i && (!cur_valid_q || (out_ld && is_last));

  // Byte sequencing and output register control.
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    done_d      = done_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (out_ld) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_q.bytes[idx_q];
      done_d      = is_last;
      idx_d       = idx_q + 1'b1;
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      cur_d       = q_item_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    done_q     <= done_d;
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign char_done_o = done_q;

endmodule

/* rtl/unicode_char_encoder_core.sv */
// Character encoder top level: Latin-1, UTF-8 and UTF-16 byte output from code points.
// Path: a character is written into the queue, taken into the back end's current-character register,
// and its bytes then go in turn to the output byte register. Throughput: one output byte per cycle while
// the output is popped, as set by the single output byte register; the queue lets input run ahead meanwhile.
// Reset: asynchronous, clears the mode to Latin-1 and empties the queue and the output register.
module unicode_char_encoder_core #(
  parameter int unsigned QueueDepth = uce_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_point_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        char_done_o
);
  import uce_pkg::*;

  logic      q_push, q_pop, q_full, q_empty;
  enc_item_t q_wdata, q_rdata;

  // Input side is stalled only by a full character queue.
  assign full = q_full;

  uce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .code_point_i (code_point_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_wdata)
  );

  uce_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  uce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .char_done_o (char_done_o)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("character queue written while full");

  // The back end never reads from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("character queue read while empty");

  // No result is offered in the cycle after reset is seen low.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered during reset");

endmodule

/* tb/tb_unicode_char_encoder_core.sv */
// Testbench for the character encoder core: directed and random code points checked byte by byte.
module tb_unicode_char_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import uce_pkg::*;

  localparam logic [7:0] QuestionMark = 8'h3F;
  // Cycles allowed for a character that yields no bytes to leave the block.
  localparam int SettleCycles = 24;
  // Marks a table row whose bytes come from the predictor.
  localparam int Computed = -1;
  localparam int NumCases = 23;
  localparam int CharsPerSetting = 5;

  // One encoded byte as seen on the output side.
  typedef struct packed {
    logic [7:0] b;
    logic       done;
  } enc_byte_t;

  // One directed row: mode, code point, byte count and bytes with the first byte on top.
  typedef struct packed {
    enc_mode_e   mode;
    logic [31:0] cp;
    int          n_typed;
    logic [31:0] typed;
  } char_case_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_wdata_i  = 2'd0;
  logic        push         = 1'b0;
  logic [31:0] code_point_i = 32'd0;
  logic        pop          = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte_o;
  logic        char_done_o;

  enc_mode_e   cur_mode = ModeLatin1;
  enc_byte_t   pending_bytes[$];
  int          errors        = 0;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;

  char_case_t char_cases [NumCases] = '{
    // Latin-1 straight after reset, including the replacement byte.
    '{ModeLatin1,  32'h0000_0000, 1,        32'h0000_0000},
    '{ModeLatin1,  32'h0000_00FF, 1,        32'hFF00_0000},
    '{ModeLatin1,  32'h0000_0100, 1,        32'h3F00_0000},
    '{ModeLatin1,  32'hFFFF_FFFF, 1,        32'h3F00_0000},
    '{ModeLatin1,  32'h0000_0041, Computed, 32'h0},
    // UTF-8 range edges, a surrogate, beyond U+10FFFF and dropped code points.
    '{ModeUtf8,    32'h0000_007F, 1,        32'h7F00_0000},
    '{ModeUtf8,    32'h0000_0080, 2,        32'hC280_0000},
    '{ModeUtf8,    32'h0000_07FF, 2,        32'hDFBF_0000},
    '{ModeUtf8,    32'h0000_0800, 3,        32'hE0A0_8000},
    '{ModeUtf8,    32'h0000_FFFF, 3,        32'hEFBF_BF00},
    '{ModeUtf8,    32'h0000_D800, 3,        32'hEDA0_8000},
    '{ModeUtf8,    32'h0001_0000, 4,        32'hF090_8080},
    '{ModeUtf8,    32'h0010_FFFF, 4,        32'hF48F_BFBF},
    '{ModeUtf8,    32'h001F_FFFF, 4,        32'hF7BF_BFBF},
    '{ModeUtf8,    32'h0020_0000, 0,        32'h0},
    '{ModeUtf8,    32'hFFFF_FFFF, 0,        32'h0},
    '{ModeUtf8,    32'h0000_20AC, Computed, 32'h0},
    // UTF-16 in both byte orders; upper bits are simply dropped.
    '{ModeUtf16Le, 32'h0000_1234, 2,        32'h3412_0000},
    '{ModeUtf16Le, 32'hFFFF_FFFF, 2,        32'hFFFF_0000},
    '{ModeUtf16Le, 32'h0001_ABCD, 2,        32'hCDAB_0000},
    '{ModeUtf16Be, 32'h0000_1234, 2,        32'h1234_0000},
    '{ModeUtf16Be, 32'h0000_0000, 2,        32'h0000_0000},
    '{ModeUtf16Be, 32'h1234_5678, Computed, 32'h0}
  };

  unicode_char_encoder_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .code_point_i (code_point_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .char_done_o  (char_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Computes the byte run of one character; returns the number of bytes.
  function automatic int encode_char(input logic [31:0] cp, input enc_mode_e mode,
                                     output logic [3:0][7:0] run);
    run = '0;
    case (mode)
      ModeLatin1: begin
        run[0] = (cp <= 32'd255) ? cp[7:0] : QuestionMark;
        return 1;
      end
      ModeUtf8: begin
        if (cp < 32'h80) begin
          run[0] = cp[7:0];
          return 1;
        end
        if (cp < 32'h800) begin
          run[0] = 8'(cp >> 6) | 8'hC0;
          run[1] = 8'(cp & 32'h3F) | 8'h80;
          return 2;
        end
        if (cp < 32'h10000) begin
          run[0] = 8'(cp >> 12) | 8'hE0;
          run[1] = 8'((cp >> 6) & 32'h3F) | 8'h80;
          run[2] = 8'(cp & 32'h3F) | 8'h80;
          return 3;
        end
        if (cp < 32'h200000) begin
          run[0] = 8'(cp >> 18) | 8'hF0;
          run[1] = 8'((cp >> 12) & 32'h3F) | 8'h80;
          run[2] = 8'((cp >> 6) & 32'h3F) | 8'h80;
          run[3] = 8'(cp & 32'h3F) | 8'h80;
          return 4;
        end
        return 0;
      end
      ModeUtf16Le: begin
        run[0] = cp[7:0];
        run[1] = cp[15:8];
        return 2;
      end
      default: begin
        run[0] = cp[15:8];
        run[1] = cp[7:0];
        return 2;
      end
    endcase
  endfunction

  // Random code point, weighted toward every encoding range and its edges.
  function automatic logic [31:0] pick_code_point();
    logic [31:0] edges [10];
    edges = '{32'h7F, 32'h80, 32'hFF, 32'h100, 32'h7FF, 32'h800, 32'hFFFF,
              32'h10000, 32'h1FFFFF, 32'h200000};
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 32'h7F);
      1:       return $urandom_range(32'h80, 32'h7FF);
      2:       return $urandom_range(32'h800, 32'hFFFF);
      3:       return $urandom_range(32'hD800, 32'hDFFF);
      4:       return $urandom_range(32'h10000, 32'h1FFFFF);
      5:       return $urandom_range(0, 255);
      6:       return $urandom();
      default: return edges[$urandom_range(0, 9)];
    endcase
  endfunction

  // Offers one code point until its transfer, then records the bytes it must produce.
  task automatic send_char(input logic [31:0] cp, input int n_typed, input logic [31:0] typed);
    logic [3:0][7:0] run;
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    code_point_i <= cp;
    do @(posedge clk_i); while (full);
    if (n_typed == Computed) begin
      n = encode_char(cp, cur_mode, run);
    end else begin
      n = n_typed;
      for (int k = 0; k < 4; k++) run[k] = typed[31 - 8 * k -: 8];
    end
    for (int k = 0; k < n; k++) pending_bytes.push_back(enc_byte_t'{run[k], k == n - 1});
  endtask

  // Stops input, lets every expected byte arrive and gives dropped characters time to clear.
  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Changes the encoding once the block is idle.
  task automatic set_mode(input enc_mode_e mode);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = mode;
  endtask

  // Output side: random stalls and a field-by-field check of every byte transfer.
  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual byte %h done %b",
                 $time, out_byte_o, char_done_o);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_o !== want.b) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.b, out_byte_o);
          errors++;
        end
        if (char_done_o !== want.done) begin
          $display("%0t: char_done mismatch: expected %b, actual %b",
                   $time, want.done, char_done_o);
          errors++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Stimulus: directed table, then random characters across idle phases and modes.
  initial begin
    int send_pct [4];
    int stall_pct [4];
    send_pct  = '{0, 58, 0, 13};
    stall_pct = '{0, 0, 58, 13};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumCases; i++) begin
      if (char_cases[i].mode != cur_mode) set_mode(char_cases[i].mode);
      send_char(char_cases[i].cp, char_cases[i].n_typed, char_cases[i].typed);
    end

    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 4; m++) begin
        set_mode(enc_mode_e'((m + p) % 4));
        send_idle_pct = send_pct[p];
        pop_stall_pct = stall_pct[p];
        for (int j = 0; j < CharsPerSetting; j++) send_char(pick_code_point(), Computed, '0);
      end
    end

    drain_and_settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/uce_pkg.sv
rtl/uce_front.sv
rtl/uce_queue.sv
rtl/uce_back.sv
rtl/unicode_char_encoder_core.sv
tb/tb_unicode_char_encoder_core.sv
